// ===== hdl/cid_pkg.sv =====
`timescale 1ns / 1ps

package cid_pkg;

	// Message and field sizes.
	localparam int unsigned DIGITS_PER_EVENT = 16;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned CTR_W = 16;
	localparam int unsigned FIRST_TO_W = 14;
	localparam int unsigned NEXT_TO_W = 12;
	localparam int unsigned CFG_DATA_W = 14;

	// Configuration register indexes.
	localparam logic CFG_FIRST_TIMEOUT = 1'b0;
	localparam logic CFG_NEXT_TIMEOUT = 1'b1;

	// Request types.
	localparam logic [1:0] REQ_DIGIT = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_HANGUP = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_CHECKSUM = 3'd1;
	localparam logic [2:0] ST_FORMAT = 3'd2;
	localparam logic [2:0] ST_BAD_CHAR = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_CALL_END = 3'd5;

	// Special symbols.
	localparam logic [3:0] SYM_D = 4'd15;

	// Request word.
	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] digit_code;
	} req_word_t;

	// Result word.
	typedef struct packed {
		logic [2:0]         status;
		logic [63:0]        event_digits;
		logic [COUNT_W-1:0] digits_held;
		logic               handshake_next;
		logic [CTR_W-1:0]   events_total;
		logic [CTR_W-1:0]   ack_retry_total;
		logic [CTR_W-1:0]   checksum_error_total;
		logic [CTR_W-1:0]   format_error_total;
	} res_word_t;

	// Checksum weight of a symbol: zero weighs ten, star through C weigh 11 to 15.
	function automatic logic [3:0] symbol_weight(input logic [3:0] code);
		logic [3:0] w;
		if (code == 4'd0) begin
			w = 4'd10;
		end else if (code <= 4'd9) begin
			w = code;
		end else begin
			w = code + 4'd1;
		end
		return w;
	endfunction

	// Counter increment that holds at the top value.
	function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

// ===== hdl/contact_id_event_receiver_top.sv =====
`timescale 1ns / 1ps
// A request word is registered in the input stage, and the result word it yields is
// registered in the output register, where it waits until it is taken.
// Throughput: one request word per cycle; the input stage stalls only when a word that
// yields a result finds the output register full and not being taken.
// Reset: arst_n clears all attempt and call state and the input and output valid flags, and
// sets the timeouts to 2000 ms before the first digit and 200 ms between digits.

module contact_id_event_receiver_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  cid_pkg::req_word_t              req_word,
	output logic                            res_valid,
	input  logic                            res_ready,
	output cid_pkg::res_word_t              res_word,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [cid_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cid_pkg::*;

	logic                  valid_s1;
	req_word_t             word_s1;
	logic                  advance;
	logic                  has_result;
	res_word_t             result;
	logic [FIRST_TO_W-1:0] first_timeout_q;
	logic [NEXT_TO_W-1:0]  next_timeout_q;

	// Timeout registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_timeout_q <= FIRST_TO_W'(2000);
			next_timeout_q <= NEXT_TO_W'(200);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_TIMEOUT: first_timeout_q <= cfg_data;
				CFG_NEXT_TIMEOUT: next_timeout_q <= cfg_data[NEXT_TO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A word moves on unless its result would overwrite one still waiting.
	assign advance = valid_s1 && (!has_result || !res_valid || res_ready);

	cid_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1)
	);

	cid_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.word          (word_s1),
		.first_timeout (first_timeout_q),
		.next_timeout  (next_timeout_q),
		.has_result    (has_result),
		.result        (result)
	);

	cid_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && has_result),
		.result    (result),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

// ===== hdl/cid_in_reg.sv =====
`timescale 1ns / 1ps

module cid_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  cid_pkg::req_word_t req_word,
	input  logic              advance,
	output logic              valid_s1,
	output cid_pkg::req_word_t word_s1
);
	import cid_pkg::*;

	// The stage takes a new word when it is empty or its word moves on.
	assign req_ready = !valid_s1 || advance;

	// Valid flag of the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Payload of the input stage.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			word_s1 <= req_word;
		end
	end

endmodule

// ===== hdl/cid_core.sv =====
`timescale 1ns / 1ps

module cid_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  cid_pkg::req_word_t                word,
	input  logic [cid_pkg::FIRST_TO_W-1:0]    first_timeout,
	input  logic [cid_pkg::NEXT_TO_W-1:0]     next_timeout,
	output logic                              has_result,
	output cid_pkg::res_word_t                result
);
	import cid_pkg::*;

	// Attempt and call state.
	logic [63:0]          store_q;
	logic [COUNT_W-1:0]   count_q;
	logic [3:0]           sum_q;
	logic                 bad_q;
	logic [FIRST_TO_W-1:0] elapsed_q;
	logic                 got_q;
	logic [CTR_W-1:0]     event_q;
	logic [CTR_W-1:0]     retry_q;
	logic [CTR_W-1:0]     cksum_q;
	logic [CTR_W-1:0]     format_q;

	logic [63:0]          store_d;
	logic [COUNT_W-1:0]   count_d;
	logic [3:0]           sum_d;
	logic                 bad_d;
	logic [FIRST_TO_W-1:0] elapsed_d;
	logic                 got_d;
	logic [CTR_W-1:0]     event_d;
	logic [CTR_W-1:0]     retry_d;
	logic [CTR_W-1:0]     cksum_d;
	logic [CTR_W-1:0]     format_d;

	logic [63:0]           digit_store;
	logic [4:0]            sum_raw;
	logic [3:0]            sum_upd;
	logic [COUNT_W-1:0]    count_inc;
	logic                  bad_upd;
	logic [FIRST_TO_W-1:0] limit;
	logic                  got_upd;
	logic [3:0]            nib_a;
	logic [3:0]            nib_b;

	// Values a digit would produce.
	always_comb begin
		digit_store = store_q | ({60'd0, word.digit_code} << {~count_q[3:0], 2'b00});
		sum_raw = {1'b0, sum_q} + {1'b0, symbol_weight(word.digit_code)};
		if (word.digit_code == SYM_D) begin
			sum_upd = sum_q;
		end else if (sum_raw >= 5'd15) begin
			sum_upd = 4'(sum_raw - 5'd15);
		end else begin
			sum_upd = sum_raw[3:0];
		end
		count_inc = count_q + 1'b1;
		bad_upd = bad_q || (word.digit_code == SYM_D);
		nib_a = digit_store[47:44];
		nib_b = digit_store[43:40];
	end

	// Timeout limit and the handshake flag a timeout would leave.
	assign limit = (count_q != '0) ? {{(FIRST_TO_W-NEXT_TO_W){1'b0}}, next_timeout}
		: first_timeout;
	assign got_upd = got_q || (count_q != '0);

	// Next state and result for the word at hand.
	always_comb begin
		store_d = store_q;
		count_d = count_q;
		sum_d = sum_q;
		bad_d = bad_q;
		elapsed_d = elapsed_q;
		got_d = got_q;
		event_d = event_q;
		retry_d = retry_q;
		cksum_d = cksum_q;
		format_d = format_q;
		has_result = 1'b0;
		result.status = ST_CALL_END;
		result.event_digits = store_q;
		result.digits_held = count_q;
		result.handshake_next = 1'b1;
		case (word.req_type)
			REQ_HANGUP: begin
				has_result = 1'b1;
				store_d = '0;
				count_d = '0;
				sum_d = '0;
				bad_d = 1'b0;
				elapsed_d = '0;
				got_d = 1'b0;
				event_d = '0;
				retry_d = '0;
				cksum_d = '0;
				format_d = '0;
			end
			REQ_TICK: begin
				if (elapsed_q < limit) begin
					elapsed_d = elapsed_q + 1'b1;
				end else begin
					has_result = 1'b1;
					result.status = ST_TIMEOUT;
					if (!got_q) begin
						got_d = got_upd;
						retry_d = sat_inc(retry_q);
					end
					result.handshake_next = !got_upd;
					store_d = '0;
					count_d = '0;
					sum_d = '0;
					bad_d = 1'b0;
					elapsed_d = '0;
				end
			end
			REQ_DIGIT: begin
				store_d = digit_store;
				count_d = count_inc;
				sum_d = sum_upd;
				bad_d = bad_upd;
				elapsed_d = '0;
				if (count_inc == COUNT_W'(DIGITS_PER_EVENT)) begin
					// The message is complete: check it and start a new attempt.
					has_result = 1'b1;
					got_d = 1'b1;
					result.event_digits = digit_store;
					result.digits_held = count_inc;
					result.handshake_next = 1'b0;
					if (bad_upd) begin
						result.status = ST_BAD_CHAR;
					end else if (sum_upd != 4'd0) begin
						result.status = ST_CHECKSUM;
						cksum_d = sat_inc(cksum_q);
					end else if (nib_b == 4'd8 && (nib_a == 4'd1 || nib_a == 4'd9)) begin
						result.status = ST_ACCEPTED;
						event_d = sat_inc(event_q);
					end else begin
						result.status = ST_FORMAT;
						format_d = sat_inc(format_q);
					end
					store_d = '0;
					count_d = '0;
					sum_d = '0;
					bad_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
		// Counters are reported after this outcome is counted.
		result.events_total = (word.req_type == REQ_HANGUP) ? event_q : event_d;
		result.ack_retry_total = (word.req_type == REQ_HANGUP) ? retry_q : retry_d;
		result.checksum_error_total = (word.req_type == REQ_HANGUP) ? cksum_q : cksum_d;
		result.format_error_total = (word.req_type == REQ_HANGUP) ? format_q : format_d;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			bad_q <= 1'b0;
			elapsed_q <= '0;
			got_q <= 1'b0;
			event_q <= '0;
			retry_q <= '0;
			cksum_q <= '0;
			format_q <= '0;
		end else if (step) begin
			store_q <= store_d;
			count_q <= count_d;
			sum_q <= sum_d;
			bad_q <= bad_d;
			elapsed_q <= elapsed_d;
			got_q <= got_d;
			event_q <= event_d;
			retry_q <= retry_d;
			cksum_q <= cksum_d;
			format_q <= format_d;
		end
	end

endmodule

// ===== hdl/cid_out_reg.sv =====
`timescale 1ns / 1ps

module cid_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  cid_pkg::res_word_t result,
	output logic               res_valid,
	input  logic               res_ready,
	output cid_pkg::res_word_t res_word
);
	import cid_pkg::*;

	logic               valid_q;
	res_word_t          word_q;

	// Valid flag: set on a new result, cleared once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= result;
		end
	end

	assign res_valid = valid_q;
	assign res_word = word_q;

endmodule

// ===== tb/sv/contact_id_event_receiver_checker.sv =====
`timescale 1ns / 1ps

module contact_id_event_receiver_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  cid_pkg::req_word_t              req_word,
	input  logic                            res_valid,
	input  logic                            res_ready,
	input  cid_pkg::res_word_t              res_word,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [cid_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatch_count,
	output int                              expected_left
);

	import cid_pkg::*;

	localparam logic [FIRST_TO_W-1:0] FIRST_RESET_MS = 14'd2000;
	localparam logic [NEXT_TO_W-1:0]  NEXT_RESET_MS = 12'd200;
	localparam int unsigned           CHECKSUM_MOD = 15;
	// Message type digits: "18" and "98".
	localparam logic [3:0]            MT_LEAD_1 = 4'd1;
	localparam logic [3:0]            MT_LEAD_9 = 4'd9;
	localparam logic [3:0]            MT_TAIL = 4'd8;

	// Timeout registers as this side sees them.
	logic [FIRST_TO_W-1:0] first_limit_ms;
	logic [NEXT_TO_W-1:0]  next_limit_ms;

	// Attempt state.
	logic [63:0]           collected;
	logic [COUNT_W-1:0]    collected_n;
	logic [3:0]            checksum_acc;
	logic                  saw_symbol_d;
	logic [FIRST_TO_W-1:0] quiet_ms;

	// Call state.
	logic                  message_seen;
	logic [CTR_W-1:0]      accepted_events;
	logic [CTR_W-1:0]      handshake_retries;
	logic [CTR_W-1:0]      checksum_errors;
	logic [CTR_W-1:0]      format_errors;

	res_word_t             expected_reports[$];

	// Checksum weight: zero counts as ten, star through C as 11 to 15.
	function automatic int unsigned dtmf_weight(input logic [3:0] sym);
		return (sym == 4'd0) ? 10 : (sym > 4'd9) ? int'(sym) + 1 : int'(sym);
	endfunction

	function automatic logic [CTR_W-1:0] count_up(input logic [CTR_W-1:0] v);
		return (v == {CTR_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// The word the block should send for an outcome, with the counters as they stand.
	function automatic res_word_t snapshot(input logic [2:0] st, input logic hs);
		res_word_t r;
		r.status = st;
		r.event_digits = collected;
		r.digits_held = collected_n;
		r.handshake_next = hs;
		r.events_total = accepted_events;
		r.ack_retry_total = handshake_retries;
		r.checksum_error_total = checksum_errors;
		r.format_error_total = format_errors;
		return r;
	endfunction

	task automatic start_attempt();
		collected = '0;
		collected_n = '0;
		checksum_acc = '0;
		saw_symbol_d = 1'b0;
		quiet_ms = '0;
	endtask

	task automatic clear_call();
		start_attempt();
		message_seen = 1'b0;
		accepted_events = '0;
		handshake_retries = '0;
		checksum_errors = '0;
		format_errors = '0;
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("t=%0t %s: got %0h, expected %0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// Work out what one accepted request word leads to.
	task automatic take_request(input req_word_t w);
		logic [FIRST_TO_W-1:0] limit;
		logic [2:0]            outcome;
		int                    slot;
		case (w.req_type)
			REQ_HANGUP: begin
				expected_reports.push_back(snapshot(ST_CALL_END, 1'b1));
				clear_call();
			end
			REQ_TICK: begin
				limit = (collected_n != 0) ? {2'b00, next_limit_ms} : first_limit_ms;
				if (quiet_ms < limit) begin
					quiet_ms = quiet_ms + 1'b1;
				end else begin
					// Until a message completes or a timeout cuts one short, every timeout is a handshake retry.
					if (!message_seen) begin
						message_seen = (collected_n != 0);
						handshake_retries = count_up(handshake_retries);
					end
					expected_reports.push_back(snapshot(ST_TIMEOUT, !message_seen));
					start_attempt();
				end
			end
			REQ_DIGIT: begin
				slot = 63 - 4 * int'(collected_n);
				collected[slot -: 4] = w.digit_code;
				if (w.digit_code == SYM_D) begin
					saw_symbol_d = 1'b1;
				end else begin
					checksum_acc = 4'((checksum_acc + dtmf_weight(w.digit_code)) % CHECKSUM_MOD);
				end
				collected_n = collected_n + 1'b1;
				quiet_ms = '0;
				if (collected_n == DIGITS_PER_EVENT) begin
					message_seen = 1'b1;
					if (saw_symbol_d) begin
						outcome = ST_BAD_CHAR;
					end else if (checksum_acc != 0) begin
						outcome = ST_CHECKSUM;
						checksum_errors = count_up(checksum_errors);
					end else if (collected[43:40] == MT_TAIL &&
							(collected[47:44] == MT_LEAD_1 || collected[47:44] == MT_LEAD_9)) begin
						// Digits 4 and 5 carry the message type.
						outcome = ST_ACCEPTED;
						accepted_events = count_up(accepted_events);
					end else begin
						outcome = ST_FORMAT;
						format_errors = count_up(format_errors);
					end
					expected_reports.push_back(snapshot(outcome, 1'b0));
					start_attempt();
				end
			end
			default: begin
			end
		endcase
	endtask

	// Compare one result word with the oldest expectation, field by field.
	task automatic compare_report(input res_word_t got);
		res_word_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch("result word with nothing pending, status", got.status, '0);
		end else begin
			want = expected_reports.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", got.status, want.status);
			if (got.event_digits !== want.event_digits)
				report_mismatch("event_digits", got.event_digits, want.event_digits);
			if (got.digits_held !== want.digits_held)
				report_mismatch("digits_held", got.digits_held, want.digits_held);
			if (got.handshake_next !== want.handshake_next)
				report_mismatch("handshake_next", got.handshake_next, want.handshake_next);
			if (got.events_total !== want.events_total)
				report_mismatch("events_total", got.events_total, want.events_total);
			if (got.ack_retry_total !== want.ack_retry_total)
				report_mismatch("ack_retry_total", got.ack_retry_total, want.ack_retry_total);
			if (got.checksum_error_total !== want.checksum_error_total)
				report_mismatch("checksum_error_total", got.checksum_error_total,
					want.checksum_error_total);
			if (got.format_error_total !== want.format_error_total)
				report_mismatch("format_error_total", got.format_error_total,
					want.format_error_total);
		end
	endtask

	// Results are checked before the request of the same edge is predicted;
	// a result never belongs to a word accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_limit_ms = FIRST_RESET_MS;
			next_limit_ms = NEXT_RESET_MS;
			clear_call();
			expected_reports.delete();
			mismatch_count = 0;
		end else begin
			if (res_valid && res_ready) begin
				compare_report(res_word);
			end
			if (cfg_we) begin
				if (cfg_index == CFG_FIRST_TIMEOUT) begin
					first_limit_ms = cfg_data[FIRST_TO_W-1:0];
				end else begin
					next_limit_ms = cfg_data[NEXT_TO_W-1:0];
				end
			end
			if (req_valid && req_ready) begin
				take_request(req_word);
			end
		end
		expected_left = expected_reports.size();
	end

endmodule

// ===== tb/sv/contact_id_event_receiver_top_tb.sv =====
`timescale 1ns / 1ps

module contact_id_event_receiver_top_tb;

	import cid_pkg::*;

	localparam logic [1:0]  REQ_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned FIRST_MS_MIN = 1000;
	localparam int unsigned FIRST_MS_MAX = 10000;
	localparam int unsigned NEXT_MS_MIN = 110;
	localparam int unsigned NEXT_MS_MAX = 4000;
	// Between-digit timeouts are only provoked when that limit is short enough to be cheap.
	localparam int unsigned CHEAP_NEXT_MS = 300;
	localparam logic [3:0]  MT_LEAD_1 = 4'd1;
	localparam logic [3:0]  MT_LEAD_9 = 4'd9;
	localparam logic [3:0]  MT_TAIL = 4'd8;
	localparam logic [3:0]  MT_OTHER_TAIL = 4'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_word_t             req_word = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_word_t             res_word;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int                    mismatch_count;
	int                    expected_left;

	bit                    idle_on = 1'b1;
	int unsigned           gap_chance = 6;
	int unsigned           items_sent = 0;
	int unsigned           cur_first = 2000;
	int unsigned           cur_next = 200;
	int unsigned           cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	contact_id_event_receiver_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	contact_id_event_receiver_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_word       (req_word),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res_word       (res_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.expected_left  (expected_left)
	);

	// Result side: alternating bursts of ready and stall, or always ready once idle_on is cleared.
	always @(posedge clk) begin : ready_bursts
		int unsigned left;
		if (left == 0) begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				res_ready <= 1'b0;
				left = $urandom_range(1, 13);
			end else begin
				res_ready <= 1'b1;
				left = $urandom_range(1, 24);
			end
		end
		left = left - 1;
	end

	// Run guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one request word and hold it until it is taken, sometimes after a gap.
	task automatic send_word(input logic [1:0] kind, input logic [3:0] code);
		req_word_t w;
		w.req_type = kind;
		w.digit_code = code;
		if (idle_on && gap_chance != 0 && $urandom_range(1, gap_chance) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (kind != REQ_UNUSED) items_sent++;
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_word(REQ_TICK, 4'($urandom_range(0, 15)));
	endtask

	// Send the first n digits of a message, with short tick gaps now and then.
	// A gap of exactly the between-digit limit goes in front of digit stretch_at.
	task automatic send_message(input logic [63:0] msg, input int unsigned n,
			input int stretch_at);
		for (int k = 0; k < n; k++) begin
			if (k == stretch_at) begin
				send_ticks(cur_next);
			end else if ($urandom_range(0, 7) == 0) begin
				send_ticks($urandom_range(1, 3));
			end
			send_word(REQ_DIGIT, msg[63 - 4*k -: 4]);
		end
	endtask

	// A message with a correct checksum, typed 18 or 98 when well_typed is set.
	function automatic logic [63:0] valid_message(input bit well_typed);
		logic [63:0] msg;
		logic [3:0]  sym;
		int unsigned sum;
		msg = '0;
		sum = 0;
		for (int k = 0; k < 15; k++) begin
			sym = 4'($urandom_range(0, 14));
			msg[63 - 4*k -: 4] = sym;
		end
		if (well_typed) begin
			msg[47:44] = $urandom_range(0, 1) ? MT_LEAD_1 : MT_LEAD_9;
			msg[43:40] = MT_TAIL;
		end else if (msg[43:40] == MT_TAIL &&
				(msg[47:44] == MT_LEAD_1 || msg[47:44] == MT_LEAD_9)) begin
			msg[43:40] = MT_OTHER_TAIL;
		end
		for (int k = 0; k < 15; k++) sum += symbol_weight(msg[63 - 4*k -: 4]);
		// Exactly one symbol from 0 to C closes the sum to a multiple of 15.
		for (int c = 0; c < 15; c++) begin
			sym = 4'(c);
			if ((sum + symbol_weight(sym)) % 15 == 0) msg[3:0] = sym;
		end
		return msg;
	endfunction

	// Moving one symbol among 0..C always changes the sum modulo 15.
	function automatic logic [63:0] broken_checksum(input logic [63:0] msg);
		int          p;
		logic [3:0]  sym;
		p = $urandom_range(0, 15);
		sym = 4'((int'(msg[63 - 4*p -: 4]) + $urandom_range(1, 14)) % 15);
		msg[63 - 4*p -: 4] = sym;
		return msg;
	endfunction

	function automatic logic [63:0] with_symbol_d(input logic [63:0] msg);
		repeat ($urandom_range(1, 3)) msg[63 - 4*$urandom_range(0, 15) -: 4] = SYM_D;
		return msg;
	endfunction

	// Hold off the sender until every expected word has come, then let the pipe empty.
	task automatic wait_quiet();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_left != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_timeouts(input int unsigned first_ms, input int unsigned next_ms);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_TIMEOUT;
		cfg_data <= first_ms[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_NEXT_TIMEOUT;
		cfg_data <= next_ms[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_first = first_ms;
		cur_next = next_ms;
	endtask

	// Mostly complete messages of every outcome, plus timeouts, hangups and noise.
	task automatic run_traffic(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		bit          cheap;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			cheap = (cur_next <= CHEAP_NEXT_MS);
			if (pick < 30) begin
				send_message(valid_message(1'b1), 16, -1);
			end else if (pick < 42) begin
				send_message(broken_checksum(valid_message($urandom_range(0, 1))), 16, -1);
			end else if (pick < 52) begin
				send_message(valid_message(1'b0), 16, -1);
			end else if (pick < 60) begin
				send_message(with_symbol_d(valid_message(1'b1)), 16, -1);
			end else if (pick < 68) begin
				if (cheap) begin
					send_message({$urandom, $urandom}, $urandom_range(1, 15), -1);
					send_ticks(cur_next + 1);
				end else begin
					send_message(valid_message(1'b1), 16, -1);
				end
			end else if (pick < 73) begin
				send_message(valid_message(1'b1), 16,
					cheap ? int'($urandom_range(1, 15)) : -1);
			end else if (pick < 80) begin
				send_message({$urandom, $urandom}, $urandom_range(0, 15), -1);
				send_word(REQ_HANGUP, 4'($urandom_range(0, 15)));
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 4))
					send_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
			end else if (pick < 96) begin
				wait_quiet();
			end else begin
				case ($urandom_range(0, 2))
					0: gap_chance = 0;
					1: gap_chance = 4;
					default: gap_chance = 12;
				endcase
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored request, lone tick, empty and partial call ends,
		// the extreme symbols, then one clean message.
		send_word(REQ_UNUSED, SYM_D);
		send_word(REQ_TICK, 4'd0);
		send_word(REQ_HANGUP, 4'd0);
		send_word(REQ_DIGIT, 4'd0);
		send_word(REQ_DIGIT, SYM_D);
		send_word(REQ_HANGUP, SYM_D);
		send_message(valid_message(1'b1), 16, -1);

		// Shortest timeouts; one first-digit timeout at the start of a fresh call.
		wait_quiet();
		program_timeouts(FIRST_MS_MIN, NEXT_MS_MIN);
		send_word(REQ_HANGUP, 4'($urandom_range(0, 15)));
		send_ticks(cur_first + 1);
		run_traffic(150);

		// Longest timeouts.
		wait_quiet();
		program_timeouts(FIRST_MS_MAX, NEXT_MS_MAX);
		run_traffic(300);

		wait_quiet();
		program_timeouts($urandom_range(FIRST_MS_MIN, 1500), $urandom_range(NEXT_MS_MIN, 250));
		run_traffic(200);

		// Last stretch at full rate on both sides.
		wait_quiet();
		program_timeouts($urandom_range(FIRST_MS_MIN, FIRST_MS_MAX),
			$urandom_range(NEXT_MS_MIN, 200));
		idle_on <= 1'b0;
		run_traffic(200);

		wait_quiet();
		if (mismatch_count == 0 && expected_left == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
